// ----- hw/rtl/kthsb_pkg.sv -----
// Package for the k-th successor block: beat types, item kind and reply codes,
// configuration register map and parameter defaults.
// Used by kthsb_cfg, kthsb_seq and the top level under hw/rtl; depends on nothing.
package kthsb_pkg;

	localparam int NODE_FIELD_W = 10;
	localparam int COUNT_W      = 11;
	localparam int STEP_W       = 31;

	localparam int MAX_NODES_DEF = 1024;
	localparam int TOP_LEVEL_DEF = 30;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic REPLY_BUILD = 1'b0;
	localparam logic REPLY_QUERY = 1'b1;

	localparam int          APB_ADDR_W     = 3;
	localparam int          APB_DATA_W     = 32;
	localparam logic        REG_NODE_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [1:0]              kind;
		logic [NODE_FIELD_W-1:0] node_index;
		logic [NODE_FIELD_W-1:0] target_node;
		logic [STEP_W-1:0]       step_count;
	} in_t;

	typedef struct packed {
		logic                    reply_kind;
		logic [NODE_FIELD_W-1:0] result_node;
		logic                    query_error;
	} out_t;

	// Register state and write strobe seen by the sequencer.
	typedef struct packed {
		logic [COUNT_W-1:0] node_count;
		logic               wr;
	} cfg_t;

endpackage

// ----- hw/rtl/kthsb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are undefined until written.
module kthsb_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/kthsb_cfg.sv -----
// APB register block holding node_count.
// Depends on kthsb_pkg for the register map and the cfg_t struct.
module kthsb_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kthsb_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [kthsb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [kthsb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output kthsb_pkg::cfg_t                     cfg
);

	logic [kthsb_pkg::COUNT_W-1:0] node_count_q;
	logic                          sel_count;
	logic                          wr_count;

	assign pready    = 1'b1;
	assign sel_count = (paddr[2] == kthsb_pkg::REG_NODE_COUNT);
	assign wr_count  = psel & penable & pwrite & pready & sel_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= kthsb_pkg::NODE_COUNT_RST;
		end else if (wr_count) begin
			node_count_q <= pwdata[kthsb_pkg::COUNT_W-1:0];
		end
	end

	assign prdata = sel_count ?
		{{(kthsb_pkg::APB_DATA_W - kthsb_pkg::COUNT_W){1'b0}}, node_count_q} :
		'0;

	assign cfg.node_count = node_count_q;
	assign cfg.wr         = wr_count;

endmodule

// ----- hw/rtl/kthsb_seq.sv -----
// Sequencer and jump table: loads level 0, builds the upper levels and walks
// queries through the table one level per step. Depends on kthsb_pkg and kthsb_ram.
module kthsb_seq #(
	parameter int MAX_NODES = kthsb_pkg::MAX_NODES_DEF,
	parameter int TOP_LEVEL = kthsb_pkg::TOP_LEVEL_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kthsb_pkg::cfg_t cfg,
	input  logic            in_valid,
	output logic            in_stall,
	input  kthsb_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output kthsb_pkg::out_t out_data
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int LVL_W  = $clog2(TOP_LEVEL + 1);
	localparam int AW     = LVL_W + NODE_W;
	localparam int DEPTH  = (TOP_LEVEL + 1) * (2 ** NODE_W);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int CMP_W  = (CNT_W > kthsb_pkg::COUNT_W) ? CNT_W : kthsb_pkg::COUNT_W;
	localparam int QLEV   = (TOP_LEVEL + 1 < kthsb_pkg::STEP_W) ? TOP_LEVEL + 1 :
		kthsb_pkg::STEP_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_NODES);
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(TOP_LEVEL);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_B_RD1  = 3'd1;
	localparam logic [2:0] ST_B_RD2  = 3'd2;
	localparam logic [2:0] ST_B_WR   = 3'd3;
	localparam logic [2:0] ST_Q_STEP = 3'd4;
	localparam logic [2:0] ST_Q_DATA = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0]                        state_q;
	logic [LVL_W-1:0]                  lvl_q;
	logic [CMP_W-1:0]                  idx_q;
	logic [QLEV-1:0]                   steps_q;
	logic [kthsb_pkg::NODE_FIELD_W-1:0] cur_q;
	logic                              kind_q;
	logic                              err_q;
	logic                              built_q;
	logic                              out_valid_q;
	kthsb_pkg::out_t                   out_q;

	logic [CMP_W-1:0]                  count_eff;
	logic                              in_acc;
	logic                              node_ok;
	logic                              tgt_ok;
	logic                              load_ok;
	logic                              out_free;
	logic                              fin_go;
	logic [LVL_W-1:0]                  lvl_dn;
	logic [CMP_W-1:0]                  idx_nx;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [kthsb_pkg::NODE_FIELD_W-1:0] ram_wdata;
	logic [AW-1:0]                     ram_raddr;
	logic [kthsb_pkg::NODE_FIELD_W-1:0] ram_rdata;

	assign count_eff = (CMP_W'(cfg.node_count) < MAX_CMP) ? CMP_W'(cfg.node_count) : MAX_CMP;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign node_ok   = CMP_W'(in_data.node_index) < count_eff;
	assign tgt_ok    = CMP_W'(in_data.target_node) < MAX_CMP;
	assign load_ok   = in_acc & (in_data.kind == kthsb_pkg::KIND_LOAD) & node_ok & tgt_ok;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign fin_go    = (state_q == ST_FINISH) & out_free;
	assign lvl_dn    = lvl_q - LVL_W'(1);
	assign idx_nx    = idx_q + CMP_W'(1);

	// Table address is {level, node}; every level owns a power-of-two slice.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {LVL_W'(0), NODE_W'(in_data.node_index)};
		ram_wdata = in_data.target_node;
		ram_raddr = {lvl_q, NODE_W'(cur_q)};
		unique case (state_q)
			ST_IDLE: begin
				ram_we = load_ok;
			end
			ST_B_RD1: begin
				ram_raddr = {lvl_dn, idx_q[NODE_W-1:0]};
			end
			ST_B_RD2: begin
				ram_raddr = {lvl_dn, NODE_W'(ram_rdata)};
			end
			ST_B_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {lvl_q, idx_q[NODE_W-1:0]};
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	kthsb_ram #(
		.WIDTH(kthsb_pkg::NODE_FIELD_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			idx_q       <= '0;
			steps_q     <= '0;
			cur_q       <= '0;
			kind_q      <= kthsb_pkg::REPLY_BUILD;
			err_q       <= 1'b0;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.wr || load_ok) begin
				built_q <= 1'b0;
			end else if (fin_go && kind_q == kthsb_pkg::REPLY_BUILD) begin
				built_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.kind)
							kthsb_pkg::KIND_LOAD: begin
								// The entry goes straight into the table RAM.
							end
							kthsb_pkg::KIND_BUILD: begin
								kind_q  <= kthsb_pkg::REPLY_BUILD;
								err_q   <= 1'b0;
								lvl_q   <= LVL_W'(1);
								idx_q   <= '0;
								state_q <= (count_eff == '0) ? ST_FINISH : ST_B_RD1;
							end
							kthsb_pkg::KIND_QUERY: begin
								kind_q  <= kthsb_pkg::REPLY_QUERY;
								cur_q   <= in_data.node_index;
								lvl_q   <= '0;
								steps_q <= in_data.step_count[QLEV-1:0];
								if (!built_q || !node_ok) begin
									err_q   <= 1'b1;
									state_q <= ST_FINISH;
								end else begin
									err_q   <= 1'b0;
									state_q <= ST_Q_STEP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_B_RD1: begin
					state_q <= ST_B_RD2;
				end
				ST_B_RD2: begin
					state_q <= ST_B_WR;
				end
				ST_B_WR: begin
					if (idx_nx == count_eff) begin
						idx_q <= '0;
						if (lvl_q == TOP_LVL) begin
							state_q <= ST_FINISH;
						end else begin
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= ST_B_RD1;
						end
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_B_RD1;
					end
				end
				ST_Q_STEP: begin
					// Clear bits skip their level; a set bit waits in ST_Q_DATA for the registered read.
					if (steps_q == '0) begin
						state_q <= ST_FINISH;
					end else if (steps_q[0]) begin
						state_q <= ST_Q_DATA;
					end else begin
						steps_q <= steps_q >> 1;
						lvl_q   <= lvl_q + LVL_W'(1);
					end
				end
				ST_Q_DATA: begin
					cur_q   <= ram_rdata;
					steps_q <= steps_q >> 1;
					lvl_q   <= lvl_q + LVL_W'(1);
					state_q <= ST_Q_STEP;
				end
				ST_FINISH: begin
					if (fin_go) begin
						out_q.reply_kind  <= kind_q;
						out_q.query_error <= err_q;
						out_q.result_node <= (kind_q == kthsb_pkg::REPLY_QUERY && !err_q) ?
							cur_q : '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/kth_successor_binary_lifting.sv -----
// Top level of the k-th successor block: APB register block and sequencer.
// Depends on kthsb_pkg, kthsb_cfg, kthsb_seq (which holds the table RAM).

// The block answers k-th successor queries by binary lifting over a table of
// (TOP_LEVEL+1) levels of MAX_NODES entries, kept in one RAM with a single read
// port and registered read data. A load beat writes its entry straight into the
// table. A query beat walks the levels up to the highest set bit of step_count,
// with a dependent table read for each set bit; a query that fails its range or
// build check goes straight to its reply. A build beat reads, for each node and
// level, the node's entry on the level below and then the entry it points to,
// writes the result, and ends with a completion reply. One beat is in work at a
// time; a finished reply waits in the output register while the next beat is
// taken. The table has no clearing pass: queries and builds must only reach
// loaded entries, and node_count may be written only while the block is idle.
module kth_successor_binary_lifting #(
	parameter int MAX_NODES = kthsb_pkg::MAX_NODES_DEF,
	parameter int TOP_LEVEL = kthsb_pkg::TOP_LEVEL_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  kthsb_pkg::in_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output kthsb_pkg::out_t                  out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kthsb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [kthsb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [kthsb_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);

	kthsb_pkg::cfg_t cfg;

	kthsb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	kthsb_seq #(
		.MAX_NODES(MAX_NODES),
		.TOP_LEVEL(TOP_LEVEL)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench for kth_successor_binary_lifting: a directed table, then random phases of
// loads, builds and queries at several node counts, each reply beat checked against a predictor.
// Depends on kthsb_pkg and the RTL under hw/rtl; reads no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kthsb_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int TOP = TOP_LEVEL_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_NODE_COUNT));
	// Settling time after the last due reply, sized from a query's walk over TOP+1 levels.
	localparam int SETTLE_CYCLES = 2 * (TOP + 1) + 20;
	localparam int HOLD_CYCLES = 400;
	localparam out_t BUILD_DONE = '{reply_kind: REPLY_BUILD, result_node: '0, query_error: 1'b0};
	localparam out_t QUERY_FAIL = '{reply_kind: REPLY_QUERY, result_node: '0, query_error: 1'b1};

	typedef struct {
		bit                 is_cfg;
		logic [COUNT_W-1:0] cfg_val;
		in_t                beat;
		bit                 typed;
		out_t               want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Predictor state: the jump table, which level-0 entries were ever loaded,
	// whether the upper levels are valid, and the node_count register.
	logic [NODE_FIELD_W-1:0] lift_tbl [0:TOP][0:NODES-1];
	bit                      loaded [0:NODES-1];
	bit                      levels_ready;
	logic [COUNT_W-1:0]      node_limit;

	out_t      replies_due[$];
	plan_row_t directed_plan[$];
	int        err_count;
	int        reply_errs;
	int        hold_reqs;

	kth_successor_binary_lifting DUT (.*);

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int active_nodes();
		return (int'(node_limit) < NODES) ? int'(node_limit) : NODES;
	endfunction

	// Applies one accepted beat to the predictor state; returns 1 with the reply if one is due.
	function automatic bit predict_reply(input in_t b, output out_t r);
		int lim;
		logic [NODE_FIELD_W-1:0] cur;
		lim = active_nodes();
		r = '0;
		case (b.kind)
			KIND_LOAD: begin
				if (int'(b.node_index) < lim) begin
					lift_tbl[0][b.node_index] = b.target_node;
					loaded[b.node_index] = 1'b1;
					levels_ready = 1'b0;
				end
				return 1'b0;
			end
			KIND_BUILD: begin
				for (int lvl = 1; lvl <= TOP; lvl++)
					for (int i = 0; i < lim; i++)
						lift_tbl[lvl][i] = lift_tbl[lvl-1][lift_tbl[lvl-1][i]];
				levels_ready = 1'b1;
				r = BUILD_DONE;
				return 1'b1;
			end
			KIND_QUERY: begin
				if (!levels_ready || int'(b.node_index) >= lim) begin
					r = QUERY_FAIL;
				end else begin
					cur = b.node_index;
					for (int bit_i = 0; bit_i <= TOP; bit_i++)
						if (b.step_count[bit_i])
							cur = lift_tbl[bit_i][cur];
					r = '{reply_kind: REPLY_QUERY, result_node: cur, query_error: 1'b0};
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic in_t make_beat(input logic [1:0] kind, input int unsigned node,
			input int unsigned target, input logic [STEP_W-1:0] steps);
		in_t b;
		b.kind = kind;
		b.node_index = NODE_FIELD_W'(node);
		b.target_node = NODE_FIELD_W'(target);
		b.step_count = steps;
		return b;
	endfunction

	function automatic void plan_beat(input logic [1:0] kind, input int unsigned node,
			input int unsigned target, input logic [STEP_W-1:0] steps);
		plan_row_t r;
		r = '{is_cfg: 1'b0, cfg_val: '0, beat: make_beat(kind, node, target, steps),
			typed: 1'b0, want: '0};
		directed_plan.push_back(r);
	endfunction

	function automatic void plan_typed(input logic [1:0] kind, input int unsigned node,
			input int unsigned target, input logic [STEP_W-1:0] steps, input out_t want);
		plan_row_t r;
		r = '{is_cfg: 1'b0, cfg_val: '0, beat: make_beat(kind, node, target, steps),
			typed: 1'b1, want: want};
		directed_plan.push_back(r);
	endfunction

	function automatic void plan_cfg(input logic [COUNT_W-1:0] v);
		plan_row_t r;
		r = '{is_cfg: 1'b1, cfg_val: v, beat: '0, typed: 1'b0, want: '0};
		directed_plan.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Step counts with varied bit patterns: dense, tiny, one bit, all ones, low bits only.
	function automatic logic [STEP_W-1:0] pick_steps();
		case ($urandom_range(0, 4))
			0: return STEP_W'($urandom);
			1: return STEP_W'($urandom_range(0, 15));
			2: return STEP_W'(1) << $urandom_range(0, STEP_W - 1);
			3: return '1;
			default: return STEP_W'($urandom) >> $urandom_range(0, STEP_W - 1);
		endcase
	endfunction

	// Valid stays high from one beat to the next when no gap is chosen.
	task automatic send_beat(input in_t b, input bit eager, input bit typed, input out_t want);
		int gap;
		out_t got;
		gap = eager ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		if (predict_reply(b, got))
			replies_due.push_back(typed ? want : got);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes node_count once the block is idle, then reads it back.
	task automatic write_node_count(input logic [COUNT_W-1:0] v);
		drain_replies();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= NODE_COUNT_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		node_limit = v;
		levels_ready = 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(v)) begin
			$display("%0t: node_count read back: expected %0d, actual %0d", $time, v, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Before a build, every node in range must point inside the range and have been loaded,
	// so that no build or query reaches an entry that was never written.
	task automatic refill_successors();
		int lim;
		lim = active_nodes();
		for (int i = 0; i < lim; i++)
			if (!loaded[i] || int'(lift_tbl[0][i]) >= lim)
				send_beat(make_beat(KIND_LOAD, i, $urandom_range(0, lim - 1), pick_steps()),
					1'b0, 1'b0, '0);
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] limit_val, input int n_items,
			input int load_pct, input int builds_allowed, input bit squeeze);
		int lim;
		int sent;
		int pick;
		int builds;
		bit squeezed;
		write_node_count(limit_val);
		lim = active_nodes();
		sent = 0;
		builds = 0;
		squeezed = 1'b0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (squeeze && !squeezed && levels_ready && lim > 0 && sent >= n_items / 2) begin
				// Replies are held back while queries keep coming, so the block backs up.
				hold_reqs++;
				repeat (16)
					send_beat(make_beat(KIND_QUERY, $urandom_range(0, lim - 1), $urandom,
						pick_steps()), 1'b1, 1'b0, '0);
				squeezed = 1'b1;
				sent += 16;
			end else if (!levels_ready && builds < builds_allowed && pick < 40) begin
				refill_successors();
				send_beat(make_beat(KIND_BUILD, $urandom, $urandom, pick_steps()),
					1'b0, 1'b0, '0);
				builds++;
				sent++;
			end else if (pick < 6) begin
				send_beat(make_beat(KIND_UNUSED, $urandom, $urandom, pick_steps()),
					1'b0, 1'b0, '0);
			end else if (pick < 6 + load_pct) begin
				send_beat(make_beat(KIND_LOAD,
					lim > 0 ? $urandom_range(0, lim - 1) : $urandom_range(0, NODES - 1),
					$urandom_range(0, NODES - 1), pick_steps()), 1'b0, 1'b0, '0);
				sent++;
			end else if (pick < 12 + load_pct && lim < NODES) begin
				send_beat(make_beat(KIND_LOAD, $urandom_range(lim, NODES - 1),
					$urandom_range(0, NODES - 1), pick_steps()), 1'b0, 1'b0, '0);
				sent++;
			end else if (pick < 18 + load_pct && lim < NODES) begin
				send_beat(make_beat(KIND_QUERY, $urandom_range(lim, NODES - 1), $urandom,
					pick_steps()), 1'b0, 1'b0, '0);
				sent++;
			end else begin
				send_beat(make_beat(KIND_QUERY,
					lim > 0 ? $urandom_range(0, lim - 1) : $urandom_range(0, NODES - 1),
					$urandom, pick_steps()), 1'b0, 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin : reply_side
		int stall_left;
		int r;
		int hold_seen;
		bit stalling;
		out_t exp_r;
		out_stall = 1'b0;
		reply_errs = 0;
		hold_seen = 0;
		stall_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply beat with none pending: kind %0d node %0d error %0d",
						$time, out_data.reply_kind, out_data.result_node,
						out_data.query_error);
					reply_errs++;
				end else begin
					exp_r = replies_due.pop_front();
					if (out_data.reply_kind !== exp_r.reply_kind) begin
						$display("%0t: reply_kind: expected %0d, actual %0d", $time,
							exp_r.reply_kind, out_data.reply_kind);
						reply_errs++;
					end
					if (out_data.result_node !== exp_r.result_node) begin
						$display("%0t: result_node: expected %0d, actual %0d", $time,
							exp_r.result_node, out_data.result_node);
						reply_errs++;
					end
					if (out_data.query_error !== exp_r.query_error) begin
						$display("%0t: query_error: expected %0d, actual %0d", $time,
							exp_r.query_error, out_data.query_error);
						reply_errs++;
					end
				end
			end
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				stalling = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left <= 0) begin
				r = $urandom_range(0, 9);
				if (r < 5) begin
					stalling = 1'b0;
					stall_left = $urandom_range(1, 30);
				end else if (r < 9) begin
					stalling = 1'b1;
					stall_left = $urandom_range(1, 4);
				end else begin
					stalling = 1'b1;
					stall_left = $urandom_range(10, 60);
				end
			end
			out_stall <= stalling;
			stall_left--;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		hold_reqs = 0;
		levels_ready = 1'b0;
		node_limit = NODE_COUNT_RST;
		foreach (loaded[i])
			loaded[i] = 1'b0;

		plan_typed(KIND_QUERY, 0, 0, 0, QUERY_FAIL);
		plan_beat(KIND_UNUSED, 1023, 1023, '1);
		plan_cfg(3);
		plan_beat(KIND_LOAD, 0, 1, 0);
		plan_beat(KIND_LOAD, 1, 2, 0);
		plan_beat(KIND_LOAD, 2, 0, 0);
		// Both loads below start beyond node_count and are dropped.
		plan_beat(KIND_LOAD, 3, 0, 0);
		plan_beat(KIND_LOAD, 1023, 1023, '1);
		plan_typed(KIND_QUERY, 0, 0, 1, QUERY_FAIL);
		plan_typed(KIND_BUILD, 0, 0, 0, BUILD_DONE);
		plan_beat(KIND_QUERY, 0, 0, 0);
		plan_beat(KIND_QUERY, 2, 1023, '1);
		plan_typed(KIND_QUERY, 3, 0, 5, QUERY_FAIL);
		plan_typed(KIND_QUERY, 1023, 0, '1, QUERY_FAIL);
		plan_beat(KIND_QUERY, 1, 0, 31'h4000_0000);
		// A load after a build invalidates the upper levels.
		plan_beat(KIND_LOAD, 1, 1, 0);
		plan_typed(KIND_QUERY, 0, 0, 1, QUERY_FAIL);
		plan_typed(KIND_BUILD, 0, 0, 0, BUILD_DONE);
		plan_beat(KIND_QUERY, 1, 0, 3);
		plan_cfg(0);
		plan_beat(KIND_LOAD, 0, 0, 0);
		plan_typed(KIND_BUILD, 0, 0, 0, BUILD_DONE);
		plan_typed(KIND_QUERY, 0, 0, 0, QUERY_FAIL);
		plan_cfg(1);
		plan_typed(KIND_QUERY, 0, 0, 0, QUERY_FAIL);
		plan_beat(KIND_LOAD, 0, 0, 0);
		plan_typed(KIND_BUILD, 0, 0, 0, BUILD_DONE);
		plan_beat(KIND_QUERY, 0, 1023, '1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg)
				write_node_count(directed_plan[i].cfg_val);
			else
				send_beat(directed_plan[i].beat, 1'b0, directed_plan[i].typed,
					directed_plan[i].want);
		end

		run_phase(11'd5, 80, 8, 1000, 1'b0);
		run_phase(11'd1, 50, 10, 1000, 1'b0);
		run_phase(11'd64, 120, 4, 1000, 1'b1);
		run_phase(11'd2, 60, 10, 1000, 1'b0);
		run_phase(11'd1024, 40, 25, 0, 1'b0);
		run_phase(11'd2047, 100, 10, 0, 1'b0);
		run_phase(11'd0, 20, 10, 1000, 1'b0);
		run_phase(11'd33, 130, 5, 1000, 1'b0);
		run_phase(11'd7, 100, 10, 1000, 1'b0);

		drain_replies();
		if (err_count == 0 && reply_errs == 0)
			$display("kth_successor_binary_lifting test passed");
		else
			$display("kth_successor_binary_lifting test failed");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("kth_successor_binary_lifting test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/kthsb_pkg.sv
hw/rtl/kthsb_ram.sv
hw/rtl/kthsb_cfg.sv
hw/rtl/kthsb_seq.sv
hw/rtl/kth_successor_binary_lifting.sv
tb/tb.sv
